// ===== rtl/core/baro_compensation_fixed_point_macros.svh =====
// ----------------------------------------------------------------------------
// baro_compensation_fixed_point_macros
// assertion macros shared by the compensation core
// ----------------------------------------------------------------------------
`ifndef BARO_COMPENSATION_FIXED_POINT_MACROS_SVH
`define BARO_COMPENSATION_FIXED_POINT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BARO_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BARO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/baro_pkg.sv =====
// ----------------------------------------------------------------------------
// baro_pkg
// shared types, constants and helpers of the barometric compensation core
// ----------------------------------------------------------------------------
`default_nettype none

package baro_pkg;

    localparam int RAW_W        = 24;
    localparam int RES_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;
    localparam int NUM_STAGES   = 15;
    localparam int TEMP_STAGES  = 5;
    localparam int PRESS_STAGES = NUM_STAGES - TEMP_STAGES;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_C = 2'd2;

    localparam logic [31:0] RAW_OFS   = 32'd8388608;
    localparam logic [31:0] K1_OFS    = 32'd4459;
    localparam logic [31:0] K2_OFS    = 32'd256;
    localparam logic [31:0] K4_OFS    = 32'd120586;
    localparam logic [31:0] K5_OFS    = 32'd4443;
    localparam logic [31:0] K7_OFS    = 32'd166426;
    localparam logic [31:0] K8_OFS    = 32'd7180;
    localparam logic [31:0] CF_BASE   = 32'd2097152;
    localparam logic [31:0] P_OFS     = 32'd99880;
    localparam logic [31:0] T_BASE    = 32'd81920000;
    localparam int          FRAC_W    = 11;

    typedef struct packed {
        logic [15:0] c0s;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [12:0] c3;
        logic [31:0] k4;
        logic [31:0] k5;
        logic [12:0] c6;
        logic [31:0] k7;
        logic [31:0] k8;
        logic [13:0] c9;
        logic [9:0]  c10;
        logic [7:0]  c11;
        logic [4:0]  c12;
    } coef_t;

    typedef struct packed {
        logic [31:0]      rt;
        logic [31:0]      dt2;
        logic [RAW_W-1:0] up;
    } temp_res_t;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        asr = 32'($signed(x) >>> n);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/baro_if.sv =====
// ----------------------------------------------------------------------------
// baro_if
// valid/ready channels for raw sample words and compensated result words
// ----------------------------------------------------------------------------
`default_nettype none

interface baro_in_if;
    logic                          valid;
    logic                          ready;
    logic [baro_pkg::RAW_W-1:0]    raw_pressure;
    logic [baro_pkg::RAW_W-1:0]    raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface baro_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [baro_pkg::RES_W-1:0] temperature_centi;
    logic signed [baro_pkg::RES_W-1:0] pressure_pa;

    modport source (output valid, output temperature_centi, output pressure_pa, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_pa, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/baro_coef.sv =====
// ----------------------------------------------------------------------------
// baro_coef
// calibration registers and unpacking into the polynomial coefficients
// ----------------------------------------------------------------------------
`default_nettype none

module baro_coef (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [baro_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [baro_pkg::CFG_DATA_W-1:0]   cfg_data,
    output baro_pkg::coef_t                        coef
);

    logic [63:0] cal_a_reg;
    logic [63:0] cal_b_reg;
    logic [31:0] cal_c_reg;

    logic [15:0] r0, r1, r2, r3, r4, r5, r6, r7, r8, r9;
    logic [10:0] c1;
    logic [8:0]  c2;
    logic [17:0] c4;
    logic [14:0] c5;
    logic [18:0] c7;
    logic [12:0] c8;
    logic [31:0] k4_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                baro_pkg::CFG_IDX_A: cal_a_reg <= cfg_data;
                baro_pkg::CFG_IDX_B: cal_b_reg <= cfg_data;
                baro_pkg::CFG_IDX_C: cal_c_reg <= cfg_data[31:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        r0 = cal_a_reg[15:0];
        r1 = cal_a_reg[31:16];
        r2 = cal_a_reg[47:32];
        r3 = cal_a_reg[63:48];
        r4 = cal_b_reg[15:0];
        r5 = cal_b_reg[31:16];
        r6 = cal_b_reg[47:32];
        r7 = cal_b_reg[63:48];
        r8 = cal_c_reg[15:0];
        r9 = cal_c_reg[31:16];

        c1 = {r1[15:8], r2[2:0]};
        c2 = {r1[7:0], r4[0]};
        c4 = {r3, r0[1:0]};
        c5 = r4[15:1];
        c7 = {r6, r5[2:0]};
        c8 = r7[15:3];
        k4_sum = {14'b0, c4} + baro_pkg::K4_OFS;

        coef.c0s = {r0[15:4], 4'b0};
        coef.k1  = {21'b0, c1} + baro_pkg::K1_OFS;
        coef.k2  = {23'b0, c2} - baro_pkg::K2_OFS;
        coef.c3  = r2[15:3];
        coef.k4  = k4_sum << 4;
        coef.k5  = {17'b0, c5} - baro_pkg::K5_OFS;
        coef.c6  = r5[15:3];
        coef.k7  = {13'b0, c7} + baro_pkg::K7_OFS;
        coef.k8  = {19'b0, c8} + baro_pkg::K8_OFS;
        coef.c9  = r8[15:2];
        coef.c10 = {r9[15:8], r8[1:0]};
        coef.c11 = r9[7:0];
        coef.c12 = {r0[3:2], r7[2:0]};
    end

endmodule

`default_nettype wire

// ===== rtl/core/baro_temp.sv =====
// ----------------------------------------------------------------------------
// baro_temp
// temperature stages: delta temperature, cubic chain, result and dt2
// ----------------------------------------------------------------------------
`default_nettype none

module baro_temp (
    input  wire logic                                clk,
    input  wire logic [baro_pkg::TEMP_STAGES-1:0]    en,
    input  wire logic [baro_pkg::RAW_W-1:0]          raw_pressure,
    input  wire logic [baro_pkg::RAW_W-1:0]          raw_temperature,
    input  baro_pkg::coef_t                          coef,
    output baro_pkg::temp_res_t                      res
);

    localparam int UW = baro_pkg::RAW_W;

    logic [31:0]   dt_next;
    logic [31:0]   sum_next;

    logic [31:0]   dt0_reg;
    logic [UW-1:0] up0_reg;
    logic [31:0]   ma1_reg, mb1_reg, mc1_reg, dt1_reg;
    logic [UW-1:0] up1_reg;
    logic [31:0]   x01_2_reg, qb2_reg, qc2_reg, dt2s_reg;
    logic [UW-1:0] up2_reg;
    logic [31:0]   x01_3_reg, x02_3_reg, x03_3_reg;
    logic [UW-1:0] up3_reg;
    logic [31:0]   rt4_reg, dtb4_reg;
    logic [UW-1:0] up4_reg;

    assign dt_next  = baro_pkg::asr({8'b0, raw_temperature} - baro_pkg::RAW_OFS, 4)
                    + {16'b0, coef.c0s};
    assign sum_next = x01_3_reg + x02_3_reg + x03_3_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dt0_reg <= dt_next;
            up0_reg <= raw_pressure;
        end
        if (en[1])
        begin
            ma1_reg <= coef.k1 * dt0_reg;
            mb1_reg <= coef.k2 * dt0_reg;
            mc1_reg <= {19'b0, coef.c3} * dt0_reg;
            dt1_reg <= dt0_reg;
            up1_reg <= up0_reg;
        end
        if (en[2])
        begin
            x01_2_reg <= baro_pkg::asr(ma1_reg, 1);
            qb2_reg   <= baro_pkg::asr(mb1_reg, 14) * dt1_reg;
            qc2_reg   <= baro_pkg::asr(mc1_reg, 18) * dt1_reg;
            dt2s_reg  <= dt1_reg;
            up2_reg   <= up1_reg;
        end
        if (en[3])
        begin
            x01_3_reg <= x01_2_reg;
            x02_3_reg <= baro_pkg::asr(qb2_reg, 4);
            x03_3_reg <= baro_pkg::asr(qc2_reg, 18) * dt2s_reg;
            up3_reg   <= up2_reg;
        end
        if (en[4])
        begin
            rt4_reg  <= baro_pkg::asr(baro_pkg::T_BASE - sum_next, 15);
            dtb4_reg <= baro_pkg::asr(sum_next, 12);
            up4_reg  <= up3_reg;
        end
    end

    assign res.rt  = rt4_reg;
    assign res.dt2 = dtb4_reg;
    assign res.up  = up4_reg;

endmodule

`default_nettype wire

// ===== rtl/core/baro_press.sv =====
// ----------------------------------------------------------------------------
// baro_press
// pressure stages: offset, sensitivity, scaling and second-order correction
// ----------------------------------------------------------------------------
`default_nettype none

module baro_press (
    input  wire logic                                 clk,
    input  wire logic [baro_pkg::PRESS_STAGES-1:0]    en,
    input  baro_pkg::temp_res_t                       tin,
    input  baro_pkg::coef_t                           coef,
    output logic [31:0]                               temperature,
    output logic [31:0]                               pressure
);

    localparam int UW = baro_pkg::RAW_W;
    localparam int FW = baro_pkg::FRAC_W;

    logic [31:0]   x22_next;
    logic [31:0]   x23_next;
    logic          ge_next;
    logic [31:0]   x26_next;

    logic [31:0]   x11_0_reg, p12_0_reg, p21_0_reg, p22_0_reg, pcf_0_reg, d_0_reg, rt_0_reg;
    logic [UW-1:0] up_0_reg;
    logic [31:0]   x11_1_reg, x12_1_reg, x21_1_reg, q22_1_reg, cf_1_reg, rt_1_reg;
    logic [UW-1:0] up_1_reg;
    logic [31:0]   x13_2_reg, x23_2_reg, m10_2_reg, m11_2_reg, rt_2_reg;
    logic          ge_2_reg;
    logic [UW-1:0] up_2_reg;
    logic [31:0]   x24_3_reg, x25_3_reg, pp1_3_reg, m10_3_reg, m11_3_reg, rt_3_reg;
    logic          ge_3_reg;
    logic [31:0]   x26_4_reg, pp1_4_reg, m10_4_reg, m11_4_reg, rt_4_reg;
    logic [31:0]   pp2_5_reg, pp3_5_reg, m10_5_reg, m11_5_reg, rt_5_reg;
    logic [31:0]   pp4_6_reg, m10_6_reg, m11_6_reg, rt_6_reg;
    logic [31:0]   t31_7_reg, t32_7_reg, pp4_7_reg, rt_7_reg;
    logic [31:0]   x31_8_reg, x32_8_reg, pp4_8_reg, rt_8_reg;
    logic [31:0]   rp_9_reg, rt_9_reg;

    always_comb
    begin
        x22_next = baro_pkg::asr(q22_1_reg, 12);
        ge_next  = $signed(x21_1_reg) >= $signed(x22_next);
        x23_next = ($signed(x22_next) >= $signed(x21_1_reg)) ? (x22_next - x21_1_reg)
                                                              : (x21_1_reg - x22_next);
        if (ge_3_reg)
            x26_next = baro_pkg::asr(32'd0 - x24_3_reg - x25_3_reg, 11) + coef.k7;
        else
            x26_next = baro_pkg::asr(x24_3_reg + x25_3_reg, 11) + coef.k7;
    end

    always_ff @(posedge clk)
    begin
        // offset, sensitivity and correction products on dt2
        if (en[0])
        begin
            x11_0_reg <= coef.k5 * tin.dt2;
            p12_0_reg <= {19'b0, coef.c6} * tin.dt2;
            p21_0_reg <= coef.k8 * tin.dt2;
            p22_0_reg <= {18'b0, coef.c9} * tin.dt2;
            pcf_0_reg <= {27'b0, coef.c12} * tin.dt2;
            d_0_reg   <= tin.dt2;
            rt_0_reg  <= tin.rt;
            up_0_reg  <= tin.up;
        end
        if (en[1])
        begin
            x11_1_reg <= x11_0_reg;
            x12_1_reg <= baro_pkg::asr(baro_pkg::asr(p12_0_reg, 16) * d_0_reg, 2);
            x21_1_reg <= baro_pkg::asr(p21_0_reg, 10);
            q22_1_reg <= baro_pkg::asr(p22_0_reg, 17) * d_0_reg;
            cf_1_reg  <= baro_pkg::asr(baro_pkg::CF_BASE + pcf_0_reg, 3);
            rt_1_reg  <= rt_0_reg;
            up_1_reg  <= up_0_reg;
        end
        if (en[2])
        begin
            x13_2_reg <= baro_pkg::asr(x11_1_reg + x12_1_reg, 10) + coef.k4;
            x23_2_reg <= x23_next;
            ge_2_reg  <= ge_next;
            m10_2_reg <= cf_1_reg * {22'b0, coef.c10};
            m11_2_reg <= cf_1_reg * {24'b0, coef.c11};
            rt_2_reg  <= rt_1_reg;
            up_2_reg  <= up_1_reg;
        end
        // sensitivity split into integer and fraction parts
        if (en[3])
        begin
            x24_3_reg <= baro_pkg::asr(x23_2_reg, 11) * coef.k7;
            x25_3_reg <= baro_pkg::asr({21'b0, x23_2_reg[FW-1:0]} * coef.k7, 11);
            pp1_3_reg <= baro_pkg::asr(({8'b0, up_2_reg} - baro_pkg::RAW_OFS) - x13_2_reg, 3);
            ge_3_reg  <= ge_2_reg;
            m10_3_reg <= m10_2_reg;
            m11_3_reg <= m11_2_reg;
            rt_3_reg  <= rt_2_reg;
        end
        if (en[4])
        begin
            x26_4_reg <= x26_next;
            pp1_4_reg <= pp1_3_reg;
            m10_4_reg <= m10_3_reg;
            m11_4_reg <= m11_3_reg;
            rt_4_reg  <= rt_3_reg;
        end
        if (en[5])
        begin
            pp2_5_reg <= baro_pkg::asr(x26_4_reg, 11) * pp1_4_reg;
            pp3_5_reg <= {21'b0, x26_4_reg[FW-1:0]} * pp1_4_reg;
            m10_5_reg <= m10_4_reg;
            m11_5_reg <= m11_4_reg;
            rt_5_reg  <= rt_4_reg;
        end
        if (en[6])
        begin
            pp4_6_reg <= baro_pkg::asr(pp2_5_reg + baro_pkg::asr(pp3_5_reg, 11), 10);
            m10_6_reg <= m10_5_reg;
            m11_6_reg <= m11_5_reg;
            rt_6_reg  <= rt_5_reg;
        end
        // second-order correction
        if (en[7])
        begin
            t31_7_reg <= baro_pkg::asr(m10_6_reg, 17) * pp4_6_reg;
            t32_7_reg <= baro_pkg::asr(m11_6_reg, 15) * pp4_6_reg;
            pp4_7_reg <= pp4_6_reg;
            rt_7_reg  <= rt_6_reg;
        end
        if (en[8])
        begin
            x31_8_reg <= baro_pkg::asr(t31_7_reg, 2);
            x32_8_reg <= baro_pkg::asr(t32_7_reg, 18) * pp4_7_reg;
            pp4_8_reg <= pp4_7_reg;
            rt_8_reg  <= rt_7_reg;
        end
        if (en[9])
        begin
            rp_9_reg <= baro_pkg::asr(x31_8_reg + x32_8_reg, 15) + pp4_8_reg + baro_pkg::P_OFS;
            rt_9_reg <= rt_8_reg;
        end
    end

    assign temperature = rt_9_reg;
    assign pressure    = rp_9_reg;

endmodule

`default_nettype wire

// ===== rtl/core/baro_compensation_fixed_point.sv =====
// ----------------------------------------------------------------------------
// baro_compensation_fixed_point
// Barometric compensation core: takes a raw 24-bit pressure/temperature
// word and returns temperature in 0.01 degree units and pressure in pascal,
// computed in 32-bit wrapping fixed point from ten calibration words held in
// three write-only registers. The datapath is a 15-stage pipeline, its depth
// set by the chain of dependent 32-bit multiplies through the pressure path;
// it accepts one word per cycle while the sink is ready or a stage is empty.
// The last stage is the output register; when the sink stalls, empty stages
// upstream keep filling, and the input stalls only once every stage holds a
// word. Write calibration only while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "baro_compensation_fixed_point_macros.svh"

module baro_compensation_fixed_point (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    baro_in_if.sink                                sample_in,
    baro_out_if.source                             result_out,
    input  wire logic                              cfg_we,
    input  wire logic [baro_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [baro_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NS = baro_pkg::NUM_STAGES;
    localparam int TS = baro_pkg::TEMP_STAGES;

    baro_pkg::coef_t     coef;
    baro_pkg::temp_res_t temp_res;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] stage_en;
    logic [31:0]   temperature;
    logic [31:0]   pressure;

    // a stage may load when the sink is ready or when it or any stage after it is empty
    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            stage_en[i] = result_out.ready || (|(~valid_reg >> i));
        end
        valid_next[0]    = sample_in.valid;
        valid_next[NS-1:1] = valid_reg[NS-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= (stage_en & valid_next) | (~stage_en & valid_reg);
    end

    baro_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    baro_temp u_temp (
        .clk             (clk),
        .en              (stage_en[TS-1:0]),
        .raw_pressure    (sample_in.raw_pressure),
        .raw_temperature (sample_in.raw_temperature),
        .coef            (coef),
        .res             (temp_res)
    );

    baro_press u_press (
        .clk         (clk),
        .en          (stage_en[NS-1:TS]),
        .tin         (temp_res),
        .coef        (coef),
        .temperature (temperature),
        .pressure    (pressure)
    );

    assign sample_in.ready              = stage_en[0];
    assign result_out.valid             = valid_reg[NS-1];
    assign result_out.temperature_centi = $signed(temperature);
    assign result_out.pressure_pa       = $signed(pressure);

    `BARO_ASSERT_NEXT(a_accept_captured, sample_in.valid && sample_in.ready, valid_reg[0], "word lost")
    `BARO_ASSERT_IMP(a_stall_only_full, !sample_in.ready, &valid_reg, "stall with room")
    `BARO_ASSERT_NEXT(a_head_held, valid_reg[0] && !stage_en[0], valid_reg[0], "head word lost")

endmodule

`default_nettype wire

// ===== sim/baro_compensation_fixed_point_checker.sv =====
// ----------------------------------------------------------------------------
// baro_compensation_fixed_point_checker
// Watches the sample, result and calibration ports of the compensation core.
// Keeps its own copy of the calibration registers, computes the expected
// temperature and pressure for every accepted sample word, and compares
// each accepted result word in order against the oldest expected reading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_compensation_fixed_point_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    baro_in_if                                  in_ch,
    baro_out_if                                 out_ch,
    input  logic                                cfg_we,
    input  logic [baro_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [baro_pkg::CFG_DATA_W-1:0]     cfg_data,
    output int                                  mismatches,
    output int                                  pending
);

    localparam logic [31:0] RAW_MIDSCALE = 32'd8388608;
    localparam logic [31:0] T1_BIAS      = 32'd4459;
    localparam logic [31:0] T2_BIAS      = 32'd256;
    localparam logic [31:0] T_ZERO       = 32'd81920000;
    localparam logic [31:0] OFF_BIAS     = 32'd4443;
    localparam logic [31:0] SENS_BIAS    = 32'd120586;
    localparam logic [31:0] TC_BIAS      = 32'd7180;
    localparam logic [31:0] GAIN_BIAS    = 32'd166426;
    localparam logic [31:0] CF_ONE       = 32'd2097152;
    localparam logic [31:0] P_BASE       = 32'd99880;
    localparam logic [31:0] FRAC_MASK    = 32'h7FF;

    typedef struct packed {
        logic [31:0] temp_centi;
        logic [31:0] press_pa;
    } reading_t;

    logic [63:0] cal_a;
    logic [63:0] cal_b;
    logic [31:0] cal_c;
    reading_t    expected_readings[$];

    function automatic logic [31:0] sra(input logic [31:0] v, input int n);
        logic signed [31:0] s;
        s = v;
        return s >>> n;
    endfunction

    function automatic reading_t compensate(input logic [63:0] wa, input logic [63:0] wb,
                                            input logic [31:0] wc, input logic [23:0] up_raw,
                                            input logic [23:0] ut_raw);
        logic [31:0] r [10];
        logic [31:0] c0, c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11, c12;
        logic [31:0] up, ut, dt, dt2, x01, x02, x03, rt;
        logic [31:0] x11, x12, x13, x21, x22, x23, k7, x24, x25, x26;
        logic [31:0] pp1, pp2, pp3, pp4, cf, x31, x32, rp;
        reading_t    res;
        for (int i = 0; i < 4; i++)
        begin
            r[i]     = 32'(wa[16*i +: 16]);
            r[4 + i] = 32'(wb[16*i +: 16]);
        end
        r[8] = 32'(wc[15:0]);
        r[9] = 32'(wc[31:16]);

        // coefficient unpacking
        c0  = r[0] >> 4;
        c1  = ((r[1] & 32'hFF00) >> 5) | (r[2] & 32'd7);
        c2  = ((r[1] & 32'h00FF) << 1) | (r[4] & 32'd1);
        c3  = r[2] >> 3;
        c4  = (r[3] << 2) | (r[0] & 32'd3);
        c5  = r[4] >> 1;
        c6  = r[5] >> 3;
        c7  = (r[6] << 3) | (r[5] & 32'd7);
        c8  = r[7] >> 3;
        c9  = r[8] >> 2;
        c10 = ((r[9] & 32'hFF00) >> 6) | (r[8] & 32'd3);
        c11 = r[9] & 32'h00FF;
        c12 = ((r[0] & 32'h000C) << 1) | (r[7] & 32'd7);

        up = 32'(up_raw);
        ut = 32'(ut_raw);

        // temperature
        dt  = sra(ut - RAW_MIDSCALE, 4) + (c0 << 4);
        x01 = sra((c1 + T1_BIAS) * dt, 1);
        x02 = sra(sra((c2 - T2_BIAS) * dt, 14) * dt, 4);
        x03 = sra(sra(c3 * dt, 18) * dt, 18) * dt;
        rt  = sra(T_ZERO - x01 - x02 - x03, 15);
        dt2 = sra(x01 + x02 + x03, 12);

        // offset and sensitivity
        x11 = (c5 - OFF_BIAS) * dt2;
        x12 = sra(sra(c6 * dt2, 16) * dt2, 2);
        x13 = sra(x11 + x12, 10) + ((c4 + SENS_BIAS) << 4);
        x21 = sra((c8 + TC_BIAS) * dt2, 10);
        x22 = sra(sra(c9 * dt2, 17) * dt2, 12);
        x23 = ($signed(x22) >= $signed(x21)) ? (x22 - x21) : (x21 - x22);
        k7  = c7 + GAIN_BIAS;
        x24 = sra(x23, 11) * k7;
        x25 = sra((x23 & FRAC_MASK) * k7, 11);
        if ($signed(x21) >= $signed(x22))
            x26 = sra(32'd0 - x24 - x25, 11) + k7;
        else
            x26 = sra(x24 + x25, 11) + k7;

        pp1 = sra((up - RAW_MIDSCALE) - x13, 3);
        pp2 = sra(x26, 11) * pp1;
        pp3 = sra((x26 & FRAC_MASK) * pp1, 11);
        pp4 = sra(pp2 + pp3, 10);

        // second-order correction
        cf  = sra(CF_ONE + c12 * dt2, 3);
        x31 = sra(sra(cf * c10, 17) * pp4, 2);
        x32 = sra(sra(cf * c11, 15) * pp4, 18) * pp4;
        rp  = sra(x31 + x32, 15) + pp4 + P_BASE;

        res.temp_centi = rt;
        res.press_pa   = rp;
        return res;
    endfunction

    task automatic report(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        reading_t want;
        if (!rst_n)
        begin
            cal_a   <= '0;
            cal_b   <= '0;
            cal_c   <= '0;
            pending <= 0;
            expected_readings.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    baro_pkg::CFG_IDX_A: cal_a <= cfg_data;
                    baro_pkg::CFG_IDX_B: cal_b <= cfg_data;
                    baro_pkg::CFG_IDX_C: cal_c <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_readings.size() == 0)
                    report("result word with no reading expected");
                else
                begin
                    want = expected_readings.pop_front();
                    if (out_ch.temperature_centi !== want.temp_centi)
                        report($sformatf("temperature_centi got %0d expected %0d",
                                         out_ch.temperature_centi,
                                         $signed(want.temp_centi)));
                    if (out_ch.pressure_pa !== want.press_pa)
                        report($sformatf("pressure_pa got %0d expected %0d",
                                         out_ch.pressure_pa, $signed(want.press_pa)));
                end
            end
            if (in_ch.valid && in_ch.ready)
                expected_readings.push_back(compensate(cal_a, cal_b, cal_c,
                                                       in_ch.raw_pressure,
                                                       in_ch.raw_temperature));
            pending <= expected_readings.size();
        end
    end

endmodule

// ===== sim/baro_compensation_fixed_point_tb.sv =====
// ----------------------------------------------------------------------------
// baro_compensation_fixed_point_tb
// Drives raw pressure/temperature words into the compensation core under a
// series of calibration settings: zero, all ones, bit patterns and random
// words. Corner samples come first, then random samples with random gaps on
// both channels and one long result-side stall that backs up the pipeline.
// The checker beside the core predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module baro_compensation_fixed_point_tb;

    localparam logic [baro_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int  NUM_PHASES  = 8;
    localparam int  WORDS_EACH  = 186;
    localparam int  HOLD_CYCLES = 300;
    localparam int  TAIL_CYCLES = 20;
    localparam int  CYCLE_LIMIT = 200000;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [baro_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [baro_pkg::CFG_DATA_W-1:0]    cfg_data;
    int                                 mismatches;
    int                                 pending;
    int                                 cycles;
    bit                                 src_gaps;
    bit                                 sink_gaps;
    bit                                 hold_request;
    bit                                 hold_done;

    baro_in_if  sample_ch ();
    baro_out_if result_ch ();

    baro_compensation_fixed_point dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    baro_compensation_fixed_point_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (sample_ch),
        .out_ch     (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random stalls, plus one long hold on request
    initial
    begin
        result_ch.ready = 1'b0;
        hold_done       = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (sink_gaps && $urandom_range(0, 5) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                result_ch.ready <= 1'b1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic push_sample(input logic [23:0] up, input logic [23:0] ut);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.raw_pressure    <= up;
        sample_ch.raw_temperature <= ut;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // stop offering and wait for every outstanding result word
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic cal_write(input logic [baro_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // bits above the 32-bit register and the unused index must be ignored
    task automatic load_calibration(input logic [63:0] wa, input logic [63:0] wb,
                                    input logic [31:0] wc);
        drain();
        cal_write(baro_pkg::CFG_IDX_A, wa);
        cal_write(baro_pkg::CFG_IDX_B, wb);
        cal_write(baro_pkg::CFG_IDX_C, {32'($urandom), wc});
        cal_write(CFG_IDX_UNUSED, {32'($urandom), 32'($urandom)});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic corner_samples();
        push_sample(24'h000000, 24'h000000);
        push_sample(24'hFFFFFF, 24'hFFFFFF);
        push_sample(24'h000000, 24'hFFFFFF);
        push_sample(24'hFFFFFF, 24'h000000);
        push_sample(24'h800000, 24'h800000);
        push_sample(24'h7FFFFF, 24'h7FFFFF);
        push_sample(24'hAAAAAA, 24'h555555);
        push_sample(24'h555555, 24'hAAAAAA);
    endtask

    function automatic logic [23:0] pick_raw();
        case ($urandom_range(0, 7))
            0:       return 24'h000000;
            1:       return 24'hFFFFFF;
            2:       return 24'h800000 + 24'($urandom_range(0, 8191)) - 24'd4096;
            3:       return 24'h800000 + 24'($urandom_range(0, 2097151)) - 24'h100000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_samples(input int count);
        for (int i = 0; i < count; i++)
            push_sample(pick_raw(), pick_raw());
    endtask

    initial
    begin
        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_index                 = '0;
        cfg_data                  = '0;
        sample_ch.valid           = 1'b0;
        sample_ch.raw_pressure    = '0;
        sample_ch.raw_temperature = '0;
        src_gaps                  = 1'b1;
        sink_gaps                 = 1'b1;
        hold_request              = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration still at reset value
        corner_samples();
        load_calibration('1, '1, '1);
        corner_samples();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       load_calibration({4{16'hAAAA}}, {4{16'hAAAA}}, {2{16'hAAAA}});
                1:       load_calibration({4{16'h5555}}, {4{16'h5555}}, {2{16'h5555}});
                2:       load_calibration('0, '0, '0);
                default: load_calibration({32'($urandom), 32'($urandom)},
                                          {32'($urandom), 32'($urandom)}, 32'($urandom));
            endcase
            src_gaps  = (phase != 1) && (phase != NUM_PHASES - 1);
            sink_gaps = (phase != 1) && (phase != NUM_PHASES - 1);
            if (phase == 3)
                hold_request = 1'b1;
            random_samples(WORDS_EACH);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/baro_pkg.sv
rtl/core/baro_if.sv
rtl/core/baro_coef.sv
rtl/core/baro_temp.sv
rtl/core/baro_press.sv
rtl/core/baro_compensation_fixed_point.sv
sim/baro_compensation_fixed_point_checker.sv
sim/baro_compensation_fixed_point_tb.sv
